// ===== sv/tfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Terminated frame receiver package
// Shared constants, codes and the command and status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tfr_pkg;

  // Frame store geometry.
  localparam int BUFFER_DEPTH = 64;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int LEN_W        = $clog2(BUFFER_DEPTH + 1);

  // Fixed field widths.
  localparam int BYTE_W      = 8;
  localparam int CMD_W       = 2;
  localparam int KIND_W      = 3;
  localparam int FRAME_LEN_W = 7;
  localparam int CFG_IDX_W   = 1;

  // Input item commands.
  localparam logic [CMD_W-1:0] CMD_BYTE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ARM  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR  = 1'b1;

  // Configuration reset values.
  localparam logic [BYTE_W-1:0] ACK_TIMEOUT_RST = 8'd10;
  localparam logic [BYTE_W-1:0] TERMINATOR_RST  = 8'hFF;

  // Frame rules.
  localparam int               ACK_FRAME_LEN = 4;
  localparam logic [BYTE_W-1:0] TIMEOUT_CODE = 8'hFF;
  localparam logic [1:0]        RUN_END      = 2'd3;

  // Result item kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE     = 3'd0,
    KIND_ACK      = 3'd1,
    KIND_TIMEOUT  = 3'd2,
    KIND_OVERFLOW = 3'd3,
    KIND_SHORT    = 3'd4
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // input item taken this cycle
    logic rd_issue;  // read the store at the replay index
    logic emit;      // load the read byte into the output register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // output register can take a new item this cycle
    logic needs_read;  // offered item ends a frame that needs the store read
    logic emit_last;   // the byte being emitted is the last of the frame
  } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/tfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Terminated frame receiver controller
// Sequences the input handshake and the read and emit steps of a replay.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire tfr_pkg::dp_status_t   status_i,
  output tfr_pkg::ctl_cmd_t          cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_q, state_d;

  // Items are taken only when idle and the output register has room for an
  // immediate result.
  assign in_stall_o = (state_q != ST_IDLE) || !status_i.out_free;

  // Next state and commands.
  always_comb begin
    state_d        = state_q;
    cmd_o.accept   = 1'b0;
    cmd_o.rd_issue = 1'b0;
    cmd_o.emit     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i && !in_stall_o;
        if (cmd_o.accept && status_i.needs_read) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
        if (cmd_o.emit) begin
          state_d = status_i.emit_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A frame needing the store always starts with a read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept && status_i.needs_read |=> state_q == ST_READ)
    else $error("replay did not start with a read");

  // Emit is only reached from a read or while waiting to emit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> $past(state_q) == ST_READ || $past(state_q) == ST_EMIT)
    else $error("emit state entered without a read");

  // A replay step never overlaps an accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |-> !cmd_o.rd_issue && !cmd_o.emit)
    else $error("item accepted during a replay");

endmodule

`default_nettype wire

// ===== sv/tfr_datapath.sv =====
// ----------------------------------------------------------------------------
// Terminated frame receiver datapath
// Frame store, frame and ack wait state, configuration and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_datapath (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic [tfr_pkg::CMD_W-1:0]               cmd_i,
  input  wire logic [tfr_pkg::BYTE_W-1:0]              rx_byte_i,
  input  wire logic                                    cfg_we_i,
  input  wire logic [tfr_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  wire logic [tfr_pkg::BYTE_W-1:0]              cfg_wdata_i,
  input  wire logic                                    out_stall_i,
  output logic                                         out_valid_o,
  output logic [tfr_pkg::KIND_W-1:0]                   kind_o,
  output logic [tfr_pkg::BYTE_W-1:0]                   data_o,
  output logic [tfr_pkg::FRAME_LEN_W-1:0]              frame_length_o,
  output logic                                         last_o,
  input  wire tfr_pkg::ctl_cmd_t                       cmd_ctl_i,
  output tfr_pkg::dp_status_t                          status_o
);

  localparam int LenW   = tfr_pkg::LEN_W;
  localparam int AddrW  = tfr_pkg::ADDR_W;
  localparam int ByteW  = tfr_pkg::BYTE_W;
  localparam int FlenW  = tfr_pkg::FRAME_LEN_W;

  // Configuration registers.
  logic [ByteW-1:0] timeout_q;
  logic [ByteW-1:0] term_q;

  // Frame and ack wait state.
  logic [LenW-1:0]  wi_q, wi_d;
  logic [1:0]       run_q, run_d;
  logic             pending_q, pending_d;
  logic [ByteW-1:0] wait_q, wait_d;

  // Replay state.
  logic [LenW-1:0]  len_q, len_d;
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;
  logic             ack_mode_q, ack_mode_d;

  // Frame store and its registered read port.
  logic [ByteW-1:0] store_q [tfr_pkg::BUFFER_DEPTH];
  logic [ByteW-1:0] rd_data_q;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;

  // Output register.
  logic                 out_valid_q;
  tfr_pkg::kind_e       out_kind_q;
  logic [ByteW-1:0]     out_data_q;
  logic [FlenW-1:0]     out_len_q;
  logic                 out_last_q;

  // Item decode helpers.
  logic             full;
  logic [LenW-1:0]  wi_inc;
  logic             pend_base;
  logic [1:0]       run_base;
  logic [1:0]       run_new;
  logic             frame_end;
  logic             ack_frame;
  logic             long_frame;
  logic [ByteW-1:0] wait_inc;

  // Result produced straight from an accepted item.
  logic             imm_load;
  tfr_pkg::kind_e   imm_kind;
  logic [ByteW-1:0] imm_data;
  logic [LenW-1:0]  imm_len;

  // Decode of the offered byte against the current frame state.
  always_comb begin
    full       = (wi_q == LenW'(tfr_pkg::BUFFER_DEPTH));
    wr_addr    = full ? '0 : wi_q[AddrW-1:0];
    wi_inc     = full ? LenW'(1) : wi_q + LenW'(1);
    pend_base  = pending_q && !full;
    run_base   = full ? 2'd0 : run_q;
    run_new    = (rx_byte_i == term_q) ? run_base + 2'd1 : 2'd0;
    frame_end  = (run_new == tfr_pkg::RUN_END);
    ack_frame  = (wi_inc == LenW'(tfr_pkg::ACK_FRAME_LEN)) && pend_base;
    long_frame = (wi_inc > LenW'(tfr_pkg::ACK_FRAME_LEN));
    wait_inc   = (wait_q == '1) ? wait_q : wait_q + 8'd1;
  end

  // Status towards the controller.
  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.needs_read = (cmd_i == tfr_pkg::CMD_BYTE) && frame_end &&
                               (ack_frame || long_frame);
  assign status_o.emit_last  = ack_mode_q ||
                               ((LenW'(rd_idx_q) + LenW'(1)) == len_q);

  // Effect of an accepted item.
  always_comb begin
    wi_d       = wi_q;
    run_d      = run_q;
    pending_d  = pending_q;
    wait_d     = wait_q;
    len_d      = len_q;
    ack_mode_d = ack_mode_q;
    rd_idx_d   = rd_idx_q;
    wr_en      = 1'b0;
    imm_load   = 1'b0;
    imm_kind   = tfr_pkg::KIND_SHORT;
    imm_data   = '0;
    imm_len    = '0;
    if (cmd_ctl_i.accept) begin
      case (cmd_i)
        tfr_pkg::CMD_BYTE: begin
          wr_en     = 1'b1;
          pending_d = pend_base;
          if (frame_end) begin
            wi_d     = '0;
            run_d    = 2'd0;
            len_d    = wi_inc;
            rd_idx_d = '0;
            if (ack_frame) begin
              pending_d  = 1'b0;
              ack_mode_d = 1'b1;
            end else if (long_frame) begin
              ack_mode_d = 1'b0;
            end else begin
              imm_load = 1'b1;
              imm_kind = tfr_pkg::KIND_SHORT;
              imm_len  = wi_inc;
            end
          end else begin
            wi_d  = wi_inc;
            run_d = run_new;
            if (full) begin
              imm_load = 1'b1;
              imm_kind = tfr_pkg::KIND_OVERFLOW;
            end
          end
        end
        tfr_pkg::CMD_ARM: begin
          pending_d = 1'b1;
          wait_d    = '0;
        end
        tfr_pkg::CMD_TICK: begin
          if (pending_q) begin
            wait_d = wait_inc;
            if (wait_inc >= timeout_q) begin
              pending_d = 1'b0;
              imm_load  = 1'b1;
              imm_kind  = tfr_pkg::KIND_TIMEOUT;
              imm_data  = tfr_pkg::TIMEOUT_CODE;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (cmd_ctl_i.emit && !status_o.emit_last) begin
      rd_idx_d = rd_idx_q + AddrW'(1);
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= tfr_pkg::ACK_TIMEOUT_RST;
      term_q      <= tfr_pkg::TERMINATOR_RST;
      wi_q        <= '0;
      run_q       <= 2'd0;
      pending_q   <= 1'b0;
      wait_q      <= '0;
      len_q       <= '0;
      rd_idx_q    <= '0;
      ack_mode_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          tfr_pkg::CFG_ACK_TIMEOUT: timeout_q <= cfg_wdata_i;
          tfr_pkg::CFG_TERMINATOR:  term_q    <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      wi_q        <= wi_d;
      run_q       <= run_d;
      pending_q   <= pending_d;
      wait_q      <= wait_d;
      len_q       <= len_d;
      rd_idx_q    <= rd_idx_d;
      ack_mode_q  <= ack_mode_d;
      out_valid_q <= imm_load || cmd_ctl_i.emit || (out_valid_q && out_stall_i);
    end
  end

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= rx_byte_i;
    end
    if (cmd_ctl_i.rd_issue) begin
      rd_data_q <= store_q[rd_idx_q];
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (imm_load) begin
      out_kind_q <= imm_kind;
      out_data_q <= imm_data;
      out_len_q  <= FlenW'(imm_len);
      out_last_q <= 1'b1;
    end else if (cmd_ctl_i.emit) begin
      out_kind_q <= ack_mode_q ? tfr_pkg::KIND_ACK : tfr_pkg::KIND_BYTE;
      out_data_q <= rd_data_q;
      out_len_q  <= FlenW'(len_q);
      out_last_q <= status_o.emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign data_o         = out_data_q;
  assign frame_length_o = out_len_q;
  assign last_o         = out_last_q;

  // The write index never passes the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wi_q <= LenW'(tfr_pkg::BUFFER_DEPTH))
    else $error("write index beyond store depth");

  // A full terminator run always closes the frame, so it is never held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q != tfr_pkg::RUN_END)
    else $error("terminator run held at its end value");

  // Replay reads stay within the completed frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ctl_i.rd_issue |-> LenW'(rd_idx_q) < len_q)
    else $error("replay read beyond frame length");

endmodule

`default_nettype wire

// ===== sv/terminated_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Terminated frame receiver
// Latency: a result caused directly by an item is shown the cycle after it is taken.
// Flow: items are taken only while the controller is idle and the output register is
// free; a replayed frame end reads each frame byte from the store, then loads it into
// the output register, and an ack frame does so for its first byte, before more input.
// Reset: asynchronous, active low; clears control state and configuration, not the store.
// ----------------------------------------------------------------------------
`default_nettype none

module terminated_frame_receiver (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [tfr_pkg::CMD_W-1:0]          cmd_i,
  input  wire logic [tfr_pkg::BYTE_W-1:0]         rx_byte_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [tfr_pkg::KIND_W-1:0]              kind_o,
  output logic [tfr_pkg::BYTE_W-1:0]              data_o,
  output logic [tfr_pkg::FRAME_LEN_W-1:0]         frame_length_o,
  output logic                                    last_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [tfr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [tfr_pkg::BYTE_W-1:0]         cfg_wdata_i
);

  tfr_pkg::ctl_cmd_t   ctl_cmd;
  tfr_pkg::dp_status_t dp_status;

  // Handshake and replay sequencing.
  tfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (ctl_cmd)
  );

  // Store, frame state and output register.
  tfr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .rx_byte_i      (rx_byte_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .data_o         (data_o),
    .frame_length_o (frame_length_o),
    .last_o         (last_o),
    .cmd_ctl_i      (ctl_cmd),
    .status_o       (dp_status)
  );

endmodule

`default_nettype wire

// ===== test/terminated_frame_receiver_test.sv =====
// ----------------------------------------------------------------------------
// Terminated frame receiver testbench
// Drives byte, arm and tick items into the receiver with random gaps, predicts
// every result item from its own model of the frame store, the terminator run
// and the ack wait, and checks each result item field by field in order.
// Register settings change between phases while the receiver is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module terminated_frame_receiver_test;

  import tfr_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
  localparam int unsigned      DRAIN_CYCLES = 10;
  localparam int unsigned      QUIET_LIMIT  = 2000;
  localparam int unsigned      MAX_PRINTED  = 40;
  localparam int unsigned      CALM_EVERY   = 40;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    kind_e                  kind;
    logic [BYTE_W-1:0]      data;
    logic [FRAME_LEN_W-1:0] frame_length;
    logic                   last;
  } frame_result_t;

  // Clock, reset and the signals of the receiver.
  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_valid    = 1'b0;
  logic                   in_stall;
  logic [CMD_W-1:0]       cmd         = CMD_BYTE;
  logic [BYTE_W-1:0]      rx_byte     = '0;
  logic                   out_valid;
  logic                   out_stall   = 1'b0;
  logic [KIND_W-1:0]      kind;
  logic [BYTE_W-1:0]      data;
  logic [FRAME_LEN_W-1:0] frame_length;
  logic                   last;
  logic                   cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index   = CFG_ACK_TIMEOUT;
  logic [BYTE_W-1:0]      cfg_wdata   = '0;

  terminated_frame_receiver dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_i          (cmd),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .data_o         (data),
    .frame_length_o (frame_length),
    .last_o         (last),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata)
  );

  // Stimulus store, awaited results and run statistics.
  rx_item_t      pending_items[$];
  frame_result_t awaited_results[$];
  rx_item_t      next_item;
  int unsigned   error_count    = 0;
  int unsigned   items_queued   = 0;
  int unsigned   items_taken    = 0;
  int unsigned   results_taken  = 0;
  int unsigned   settings_used  = 1;
  int unsigned   send_hold      = 0;
  int unsigned   stall_left     = 0;
  int unsigned   quiet_cycles   = 0;
  bit            calm_tx        = 1'b0;
  bit            calm_rx        = 1'b0;

  // Shadow of the receiver: configuration and frame state.
  logic [BYTE_W-1:0] timeout_cfg = ACK_TIMEOUT_RST;
  logic [BYTE_W-1:0] term_cfg    = TERMINATOR_RST;
  logic [BYTE_W-1:0] frame_buf [BUFFER_DEPTH];
  int unsigned       fill_index  = 0;
  int unsigned       term_run    = 0;
  bit                ack_waiting = 1'b0;
  logic [BYTE_W-1:0] held_ack    = '0;
  int unsigned       ticks_seen  = 0;

  // Clock generator.
  initial begin
    forever #10 clk = ~clk;
  end

  // Counts a failure and prints it while the log is still short.
  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTED) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic void await_result(input kind_e k, input logic [BYTE_W-1:0] d,
                                       input int unsigned len, input logic lst);
    frame_result_t r;
    r.kind         = k;
    r.data         = d;
    r.frame_length = FRAME_LEN_W'(len);
    r.last         = lst;
    awaited_results.push_back(r);
  endfunction

  // Works out the result items that one accepted input item causes.
  task automatic deframe_step(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b);
    int unsigned len;
    if (c == CMD_BYTE) begin
      if (fill_index == 0 && ack_waiting) begin
        held_ack = '0;
      end
      // A full store drops the frame and starts over with this byte.
      if (fill_index >= BUFFER_DEPTH) begin
        fill_index  = 0;
        term_run    = 0;
        ack_waiting = 1'b0;
        await_result(KIND_OVERFLOW, '0, 0, 1'b1);
      end
      frame_buf[fill_index] = b;
      fill_index++;
      if (b == term_cfg) begin
        if (term_run < RUN_END) term_run++;
      end else begin
        term_run = 0;
      end
      if (term_run == RUN_END) begin
        len = fill_index;
        if (len == ACK_FRAME_LEN && ack_waiting) begin
          held_ack    = frame_buf[0];
          ack_waiting = 1'b0;
          await_result(KIND_ACK, held_ack, len, 1'b1);
        end else if (len > ACK_FRAME_LEN) begin
          for (int unsigned i = 0; i < len; i++) begin
            await_result(KIND_BYTE, frame_buf[i], len, (i + 1 == len));
          end
        end else begin
          await_result(KIND_SHORT, '0, len, 1'b1);
        end
        fill_index = 0;
        term_run   = 0;
      end
    end else if (c == CMD_ARM) begin
      ack_waiting = 1'b1;
      held_ack    = '0;
      ticks_seen  = 0;
    end else if (c == CMD_TICK && ack_waiting) begin
      if (ticks_seen < 255) ticks_seen++;
      if (ticks_seen >= timeout_cfg) begin
        held_ack    = TIMEOUT_CODE;
        ack_waiting = 1'b0;
        await_result(KIND_TIMEOUT, TIMEOUT_CODE, 0, 1'b1);
      end
    end
  endtask

  // Input driver: takes items from the pending queue with a random gap after each.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_hold = 0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_step(cmd, rx_byte);
        items_taken++;
        if (items_taken % CALM_EVERY == 0) calm_tx = ($urandom_range(0, 2) == 0);
      end
      if (!in_valid || !in_stall) begin
        if (send_hold > 0) begin
          send_hold--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          cmd       <= next_item.cmd;
          rx_byte   <= next_item.rx_byte;
          in_valid  <= 1'b1;
          send_hold = draw_wait(calm_tx);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_error($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                             results_taken, name, got, want));
    end
  endtask

  // Output monitor: checks each result item and stalls at random after it.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing awaited", results_taken));
        end else begin
          frame_result_t r;
          r = awaited_results.pop_front();
          check_field("kind", 8'(kind), 8'(r.kind));
          check_field("data", data, r.data);
          check_field("frame_length", 8'(frame_length), 8'(r.frame_length));
          check_field("last", 8'(last), 8'(r.last));
        end
        results_taken++;
        if (results_taken % CALM_EVERY == 0) calm_rx = ($urandom_range(0, 2) == 0);
        stall_left = draw_wait(calm_rx);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus helpers.
  function automatic void push_item(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b);
    rx_item_t it;
    it.cmd     = c;
    it.rx_byte = b;
    pending_items.push_back(it);
    items_queued++;
  endfunction

  function automatic void push_cmd(input logic [CMD_W-1:0] c);
    push_item(c, BYTE_W'($urandom));
  endfunction

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom);
    return (b == term_cfg) ? ~b : b;
  endfunction

  // Payload bytes, then the terminator run; stray terminators never reach three
  // in a row and never end the payload, so the frame closes where intended.
  function automatic void push_frame(input int unsigned payload, input int unsigned term_pct);
    logic [BYTE_W-1:0] b;
    int unsigned       run;
    run = 0;
    for (int unsigned i = 0; i < payload; i++) begin
      b = BYTE_W'($urandom);
      if ($urandom_range(0, 99) < term_pct) b = term_cfg;
      if (b == term_cfg && (run == 2 || i + 1 == payload)) b = ~term_cfg;
      run = (b == term_cfg) ? run + 1 : 0;
      push_item(CMD_BYTE, b);
    end
    repeat (3) push_item(CMD_BYTE, term_cfg);
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ACK_TIMEOUT: timeout_cfg = val;
      CFG_TERMINATOR:  term_cfg    = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every item is taken and every result has arrived, then drains.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random traffic: mostly well-formed frames and ack exchanges, some noise.
  task automatic random_phase(input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    int unsigned n;
    start = items_queued;
    while (items_queued - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        if ($urandom_range(0, 11) == 0) begin
          n = ($urandom_range(0, 2) == 0) ? BUFFER_DEPTH - 3 : $urandom_range(20, 61);
        end else begin
          n = $urandom_range(2, 10);
        end
        push_frame(n, 10);
      end else if (pick < 50) begin
        push_cmd(CMD_ARM);
        repeat ($urandom_range(0, 3)) push_cmd(CMD_TICK);
        push_frame(1, 0);
      end else if (pick < 62) begin
        push_cmd(CMD_ARM);
        n = (timeout_cfg > 12) ? 14 : timeout_cfg + 1;
        repeat ($urandom_range(0, n)) push_cmd(CMD_TICK);
      end else if (pick < 72) begin
        push_frame($urandom_range(0, 1), 0);
      end else if (pick < 76) begin
        // Runs past the end of the store, then closes a frame after the restart.
        if ($urandom_range(0, 1) == 1) push_cmd(CMD_ARM);
        repeat ($urandom_range(BUFFER_DEPTH, BUFFER_DEPTH + 6)) push_item(CMD_BYTE, plain_byte());
        repeat (3) push_item(CMD_BYTE, term_cfg);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) begin
          push_item(CMD_W'($urandom_range(0, 3)), BYTE_W'($urandom));
        end
      end else begin
        if ($urandom_range(0, 1) == 1) push_cmd(CMD_ARM);
        push_frame($urandom_range(1, 12), 60);
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] timeout_val;
    logic [BYTE_W-1:0] term_val;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items with the reset settings: a three-byte frame, a four-byte
    // frame with no ack awaited, an ack frame, a stray tick, the unused
    // command and the shortest replayed frame.
    @(negedge clk);
    repeat (3) push_item(CMD_BYTE, 8'hFF);
    push_item(CMD_BYTE, 8'h00);
    repeat (3) push_item(CMD_BYTE, 8'hFF);
    push_cmd(CMD_ARM);
    push_item(CMD_BYTE, 8'h5A);
    repeat (3) push_item(CMD_BYTE, 8'hFF);
    push_item(CMD_TICK, 8'h00);
    push_item(CMD_UNUSED, 8'hFF);
    push_item(CMD_BYTE, 8'h01);
    push_item(CMD_BYTE, 8'hFE);
    repeat (3) push_item(CMD_BYTE, 8'hFF);
    wait_idle();

    // Zero timeout times out on the first tick; a zero terminator lets an
    // all-ones byte be captured as the ack code.
    write_register(CFG_ACK_TIMEOUT, 8'd0);
    write_register(CFG_TERMINATOR, 8'h00);
    settings_used++;
    @(negedge clk);
    push_cmd(CMD_ARM);
    push_cmd(CMD_TICK);
    push_cmd(CMD_ARM);
    push_item(CMD_BYTE, 8'hFF);
    repeat (3) push_item(CMD_BYTE, 8'h00);
    wait_idle();

    // Random phases, each under its own register setting.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin timeout_val = 8'd1;   term_val = BYTE_W'($urandom); end
        1: begin timeout_val = 8'd255; term_val = 8'hFF; end
        2: begin timeout_val = BYTE_W'($urandom_range(2, 12)); term_val = BYTE_W'($urandom); end
        3: begin timeout_val = 8'd3;   term_val = 8'h00; end
        default: begin
          timeout_val = BYTE_W'($urandom_range(1, 255));
          term_val    = BYTE_W'($urandom);
        end
      endcase
      write_register(CFG_ACK_TIMEOUT, timeout_val);
      write_register(CFG_TERMINATOR, term_val);
      settings_used++;
      @(negedge clk);
      random_phase(90);
      wait_idle();
    end

    $display("Covered %0d input items and %0d result items under %0d register settings.",
             items_taken, results_taken, settings_used);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
